>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/ssp_pkg.sv
package ssp_pkg;

    localparam int DATA_W     = 16;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Bus operation codes carried by each item.
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH       = 3'd1;
    localparam logic [OP_W-1:0] OP_POP        = 3'd2;
    localparam logic [OP_W-1:0] OP_STATUS     = 3'd3;
    localparam logic [OP_W-1:0] OP_RAW_IRQ    = 3'd4;
    localparam logic [OP_W-1:0] OP_MASKED_IRQ = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR_OVR  = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MASK   = 3'd6;

    // Status word bit positions.
    localparam int STAT_TFE = 0;
    localparam int STAT_TNF = 1;
    localparam int STAT_RNE = 2;
    localparam int STAT_RFF = 3;
    localparam int STAT_BSY = 4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] write_data;
        logic              miso_in;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              sclk_out;
        logic              mosi_out;
        logic              select_n;
        logic              irq_out;
    } out_item_t;

    typedef struct packed {
        logic [3:0] frame_bits_minus_one;
        logic [7:0] clock_rate_divider;
        logic [7:0] prescale_divisor;
        logic       clock_polarity;
        logic       clock_phase;
        logic       port_enable;
        logic       overrun_irq_mask;
    } cfg_t;

    // Requests from the bus side into the serial engine for one tick.
    typedef struct packed {
        logic advance;
        logic tx_avail;
        logic rx_space;
        logic clear_ovr;
        logic miso;
    } eng_req_t;

    // Engine state seen by the bus side, and the pin levels after the tick.
    typedef struct packed {
        logic busy;
        logic overrun;
        logic tx_pop;
        logic rx_push;
        logic sclk;
        logic mosi;
        logic select_n;
        logic irq;
    } eng_stat_t;

endpackage

>>> sv/ssp_fifo.sv
`include "assert_macros.svh"

module ssp_fifo #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] wr_sum;
    logic [PTR_W-1:0] wr_addr;

    // The tail slot is head plus count; with a pop in the same tick this is
    // still the correct slot, since the pop frees the head entry first.
    assign wr_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
                                               : PTR_W'(wr_sum);

    // An empty queue hands a same-tick push straight through to the head.
    assign head_data = (count_reg == '0) ? push_data : mem_reg[head_reg];
    assign count     = count_reg;

    always_comb
    begin
        head_next = head_reg;
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_addr] <= push_data;
        end
    end

    `ASSERT_IMP(a_no_overflow, clk, rst_n, push && !pop, count_reg < CNT_W'(DEPTH))
    `ASSERT_IMP(a_no_underflow, clk, rst_n, pop, count_reg != '0 || push)
    `ASSERT_NXT(a_push_not_empty, clk, rst_n, push && !pop, count_reg != '0)

endmodule

>>> sv/ssp_engine.sv
module ssp_engine #(
    parameter int MAX_FRAME_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssp_pkg::cfg_t             cfg,
    input  ssp_pkg::eng_req_t         req,
    input  logic [ssp_pkg::DATA_W-1:0] tx_data,
    output ssp_pkg::eng_stat_t        stat,
    output logic [ssp_pkg::DATA_W-1:0] rx_data
);

    import ssp_pkg::*;

    localparam int SH_W  = MAX_FRAME_BITS;
    localparam int LEN_W = $clog2(MAX_FRAME_BITS + 1);
    localparam int IDX_W = $clog2(MAX_FRAME_BITS);
    localparam int TCK_W = 16;

    logic [SH_W-1:0]  shift_out_reg, shift_out_next;
    logic [SH_W-1:0]  shift_in_reg, shift_in_next;
    logic [TCK_W-1:0] tick_reg, tick_next;
    logic [LEN_W-1:0] bit_reg, bit_next;
    logic             busy_reg, busy_next;
    logic             half_reg, half_next;
    logic             overrun_reg, overrun_next;

    logic [4:0]       len_raw;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_m1;
    logic [SH_W-1:0]  mask;
    logic [6:0]       pre_half;
    logic [8:0]       rate_p1;
    logic [TCK_W-1:0] half_period;
    logic [TCK_W:0]   tick_inc;
    logic [LEN_W-1:0] bit_inc;
    logic             tx_pop;
    logic             rx_push;

    // Frame length clamped to four bits at the low end and the shifter width
    // at the high end.
    always_comb
    begin
        len_raw = {1'b0, cfg.frame_bits_minus_one} + 5'd1;
        if (len_raw < 5'd4)
        begin
            len = LEN_W'(4);
        end
        else if (32'(len_raw) > MAX_FRAME_BITS)
        begin
            len = LEN_W'(MAX_FRAME_BITS);
        end
        else
        begin
            len = LEN_W'(len_raw);
        end
    end

    assign len_m1   = len - 1'b1;
    assign mask     = ~({SH_W{1'b1}} << len);
    assign pre_half = (cfg.prescale_divisor[7:1] == '0) ? 7'd1 : cfg.prescale_divisor[7:1];
    assign rate_p1  = {1'b0, cfg.clock_rate_divider} + 9'd1;
    assign half_period = TCK_W'({9'b0, pre_half} * {7'b0, rate_p1});
    assign tick_inc = {1'b0, tick_reg} + 1'b1;
    assign bit_inc  = bit_reg + 1'b1;

    always_comb
    begin
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        busy_next      = busy_reg;
        half_next      = half_reg;
        overrun_next   = overrun_reg && !req.clear_ovr;
        tx_pop         = 1'b0;
        rx_push        = 1'b0;

        if (!busy_reg)
        begin
            if (cfg.port_enable && req.tx_avail)
            begin
                shift_out_next = SH_W'(tx_data) & mask;
                shift_in_next  = '0;
                tick_next      = '0;
                bit_next       = '0;
                half_next      = 1'b0;
                busy_next      = 1'b1;
                tx_pop         = 1'b1;
            end
        end
        else if (tick_inc < {1'b0, half_period})
        begin
            tick_next = tick_inc[TCK_W-1:0];
        end
        else
        begin
            tick_next = '0;
            if (!half_reg)
            begin
                // Mid-bit edge: sample the serial input.
                shift_in_next = {shift_in_reg[SH_W-2:0], req.miso} & mask;
                half_next     = 1'b1;
            end
            else
            begin
                half_next      = 1'b0;
                shift_out_next = {shift_out_reg[SH_W-2:0], 1'b0} & mask;
                bit_next       = bit_inc;
                if (bit_inc >= len)
                begin
                    if (req.rx_space)
                    begin
                        rx_push = 1'b1;
                    end
                    else
                    begin
                        overrun_next = 1'b1;
                    end
                    busy_next = 1'b0;
                    bit_next  = '0;
                end
            end
        end
    end

    assign rx_data = DATA_W'(shift_in_reg);

    always_comb
    begin
        stat.busy     = busy_reg;
        stat.overrun  = overrun_reg;
        stat.tx_pop   = tx_pop;
        stat.rx_push  = rx_push;
        stat.sclk     = busy_next ? (cfg.clock_polarity ^ cfg.clock_phase ^ half_next)
                                  : cfg.clock_polarity;
        stat.mosi     = busy_next ? shift_out_next[len_m1[IDX_W-1:0]] : 1'b0;
        stat.select_n = !busy_next;
        stat.irq      = overrun_next && cfg.overrun_irq_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_out_reg <= '0;
            shift_in_reg  <= '0;
            tick_reg      <= '0;
            bit_reg       <= '0;
            busy_reg      <= 1'b0;
            half_reg      <= 1'b0;
            overrun_reg   <= 1'b0;
        end
        else if (req.advance)
        begin
            shift_out_reg <= shift_out_next;
            shift_in_reg  <= shift_in_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            busy_reg      <= busy_next;
            half_reg      <= half_next;
            overrun_reg   <= overrun_next;
        end
    end

endmodule

>>> sv/spi_master_ssp_controller.sv
// Channel   Direction  Handshake                 Payload
// in        to block   in_valid / in_stall       in_item  (operation, write_data, miso_in)
// out       from block out_valid / out_stall     out_item (read_data, pins, irq_out)
// cfg       to block   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is one peripheral tick and yields one result item; the block takes an item
// every cycle unless the result side stalls. An item waits in the input register, and
// its result is registered in the result register when it advances. The tick's whole
// update (bus access, FIFOs, serial engine) is done in the single step between them.
// Reset clears FIFO counts, engine state, the overrun flag and the configuration to
// its defaults. A stalled result holds the result register; an empty input register
// still takes one item, and in_stall rises once it holds one. cfg_ready is always high.
`include "assert_macros.svh"

module spi_master_ssp_controller #(
    parameter int FIFO_DEPTH     = 8,
    parameter int MAX_FRAME_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ssp_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ssp_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import ssp_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cfg_t        cfg_reg;
    in_item_t    in_reg;
    logic        in_valid_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic        advance;
    logic [OP_W-1:0] op;
    logic        tx_push_ok;
    logic        rx_pop_ok;
    logic [CNT_W-1:0]  tx_count;
    logic [CNT_W-1:0]  rx_count;
    logic [DATA_W-1:0] tx_head;
    logic [DATA_W-1:0] rx_head;
    logic [DATA_W-1:0] rx_data;
    logic [DATA_W-1:0] read_data;
    eng_req_t    eng_req;
    eng_stat_t   eng_stat;
    out_item_t   result;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign cfg_ready = 1'b1;

    assign op         = in_reg.operation;
    assign tx_push_ok = advance && (op == OP_PUSH) && (tx_count < CNT_W'(FIFO_DEPTH));
    assign rx_pop_ok  = advance && (op == OP_POP) && (rx_count != '0);

    always_comb
    begin
        eng_req.advance   = advance;
        eng_req.tx_avail  = (tx_count != '0) || tx_push_ok;
        eng_req.rx_space  = (rx_count < CNT_W'(FIFO_DEPTH)) || rx_pop_ok;
        eng_req.clear_ovr = (op == OP_CLEAR_OVR);
        eng_req.miso      = in_reg.miso_in;
    end

    ssp_fifo #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (DATA_W)
    ) u_tx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tx_push_ok),
        .push_data (in_reg.write_data),
        .pop       (advance && eng_stat.tx_pop),
        .head_data (tx_head),
        .count     (tx_count)
    );

    ssp_fifo #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (DATA_W)
    ) u_rx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && eng_stat.rx_push),
        .push_data (rx_data),
        .pop       (rx_pop_ok),
        .head_data (rx_head),
        .count     (rx_count)
    );

    ssp_engine #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .req     (eng_req),
        .tx_data (tx_head),
        .stat    (eng_stat),
        .rx_data (rx_data)
    );

    // Bus reads see the state before the engine moves in this tick.
    always_comb
    begin
        read_data = '0;
        case (op)
            OP_POP:
            begin
                if (rx_pop_ok)
                begin
                    read_data = rx_head;
                end
            end
            OP_STATUS:
            begin
                read_data[STAT_TFE] = (tx_count == '0);
                read_data[STAT_TNF] = (tx_count < CNT_W'(FIFO_DEPTH));
                read_data[STAT_RNE] = (rx_count != '0);
                read_data[STAT_RFF] = (rx_count >= CNT_W'(FIFO_DEPTH));
                read_data[STAT_BSY] = eng_stat.busy || (tx_count != '0);
            end
            OP_RAW_IRQ:
            begin
                read_data[0] = eng_stat.overrun;
            end
            OP_MASKED_IRQ:
            begin
                read_data[0] = eng_stat.overrun && cfg_reg.overrun_irq_mask;
            end
            default:
            begin
                read_data = '0;
            end
        endcase
    end

    always_comb
    begin
        result.read_data = read_data;
        result.sclk_out  = eng_stat.sclk;
        result.mosi_out  = eng_stat.mosi;
        result.select_n  = eng_stat.select_n;
        result.irq_out   = eng_stat.irq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_bits_minus_one <= 4'd7;
            cfg_reg.clock_rate_divider   <= 8'd0;
            cfg_reg.prescale_divisor     <= 8'd2;
            cfg_reg.clock_polarity       <= 1'b0;
            cfg_reg.clock_phase          <= 1'b0;
            cfg_reg.port_enable          <= 1'b0;
            cfg_reg.overrun_irq_mask     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_BITS: cfg_reg.frame_bits_minus_one <= cfg_data[3:0];
                CFG_RATE:       cfg_reg.clock_rate_divider   <= cfg_data;
                CFG_PRESCALE:   cfg_reg.prescale_divisor     <= cfg_data;
                CFG_POLARITY:   cfg_reg.clock_polarity       <= cfg_data[0];
                CFG_PHASE:      cfg_reg.clock_phase          <= cfg_data[0];
                CFG_ENABLE:     cfg_reg.port_enable          <= cfg_data[0];
                CFG_IRQ_MASK:   cfg_reg.overrun_irq_mask     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_reg <= in_item;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    `ASSERT_IMP(a_stall_only_blocked, clk, rst_n, in_stall, out_valid_reg && out_stall)
    `ASSERT_NXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    `ASSERT_IMP(a_quiet_ops_read_zero, clk, rst_n,
        op == OP_TICK || op == OP_PUSH || op == OP_CLEAR_OVR, read_data == '0)

endmodule

>>> verif/spi_master_ssp_controller_test.sv
module spi_master_ssp_controller_test;

    import ssp_pkg::*;

    localparam int FIFO_DEPTH     = 8;
    localparam int MAX_FRAME_BITS = 16;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);
    localparam int NUM_PHASES     = 14;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CYCLE_LIMIT    = 150000;

    // Operation code with no function; the block treats it as a plain tick.
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

    typedef enum logic [1:0] {ROW_ITEM, ROW_REG, ROW_TICKS} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [OP_W-1:0]        op;
        logic [DATA_W-1:0]      data;
        logic                   miso;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [7:0]             reps;
        logic                   fixed;
        logic [DATA_W-1:0]      fixed_data;
    } plan_row_t;

    typedef struct packed {
        logic      hand;
        out_item_t val;
    } fixed_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    spi_master_ssp_controller #(
        .FIFO_DEPTH     (FIFO_DEPTH),
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the port: registers, FIFOs and serial engine.
    cfg_t              regs = '{frame_bits_minus_one: 4'd7, prescale_divisor: 8'd2,
                                default: '0};
    logic [DATA_W-1:0] tx_fifo [FIFO_DEPTH];
    logic [DATA_W-1:0] rx_fifo [FIFO_DEPTH];
    int unsigned       tx_cnt = 0, rx_cnt = 0, tx_rd = 0, rx_rd = 0;
    logic [31:0]       shreg_out = '0, shreg_in = '0;
    int unsigned       tick_cnt = 0, bit_cnt = 0;
    logic              eng_busy = 1'b0, second_half = 1'b0, overrun = 1'b0;
    int unsigned       frames_done = 0, frames_dropped = 0;

    out_item_t     tick_results_q [$];
    fixed_result_t fixed_q [$];

    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned holds_done = 0;
    logic        tx_idle_on = 1'b1;
    logic        rx_idle_on = 1'b1;
    logic        hold_outputs = 1'b0;

    // One peripheral tick: the bus access first, then the serial engine.
    task automatic advance_port(input in_item_t it, output out_item_t res);
        int unsigned       n;
        int unsigned       pre;
        int unsigned       half_ticks;
        logic [31:0]       msk;
        logic [DATA_W-1:0] rd;
        rd = '0;
        n = regs.frame_bits_minus_one + 1;
        if (n < 4)
            n = 4;
        if (n > MAX_FRAME_BITS)
            n = MAX_FRAME_BITS;
        msk = (32'd1 << n) - 32'd1;
        pre = 32'(regs.prescale_divisor & 8'hFE);
        if (pre < 2)
            pre = 2;
        half_ticks = (pre / 2) * (regs.clock_rate_divider + 1);

        case (it.operation)
            OP_PUSH:
                if (tx_cnt < FIFO_DEPTH)
                begin
                    tx_fifo[PTR_W'((tx_rd + tx_cnt) % FIFO_DEPTH)] = it.write_data;
                    tx_cnt++;
                end
            OP_POP:
                if (rx_cnt > 0)
                begin
                    rd = rx_fifo[PTR_W'(rx_rd)];
                    rx_rd = (rx_rd + 1) % FIFO_DEPTH;
                    rx_cnt--;
                end
            OP_STATUS:
            begin
                rd[STAT_TFE] = (tx_cnt == 0);
                rd[STAT_TNF] = (tx_cnt < FIFO_DEPTH);
                rd[STAT_RNE] = (rx_cnt > 0);
                rd[STAT_RFF] = (rx_cnt >= FIFO_DEPTH);
                rd[STAT_BSY] = eng_busy || (tx_cnt > 0);
            end
            OP_RAW_IRQ:    rd[0] = overrun;
            OP_MASKED_IRQ: rd[0] = overrun && regs.overrun_irq_mask;
            OP_CLEAR_OVR:  overrun = 1'b0;
            default: ;
        endcase

        if (!eng_busy)
        begin
            if (regs.port_enable && tx_cnt > 0)
            begin
                shreg_out = {16'd0, tx_fifo[PTR_W'(tx_rd)]} & msk;
                tx_rd = (tx_rd + 1) % FIFO_DEPTH;
                tx_cnt--;
                shreg_in = '0;
                tick_cnt = 0;
                bit_cnt = 0;
                second_half = 1'b0;
                eng_busy = 1'b1;
            end
        end
        else if (tick_cnt + 1 < half_ticks)
            tick_cnt++;
        else
        begin
            tick_cnt = 0;
            if (!second_half)
            begin
                // Mid-bit edge: sample the serial input.
                shreg_in = ((shreg_in << 1) | it.miso_in) & msk;
                second_half = 1'b1;
            end
            else
            begin
                second_half = 1'b0;
                shreg_out = (shreg_out << 1) & msk;
                bit_cnt++;
                if (bit_cnt >= n)
                begin
                    if (rx_cnt < FIFO_DEPTH)
                    begin
                        rx_fifo[PTR_W'((rx_rd + rx_cnt) % FIFO_DEPTH)] =
                            shreg_in[DATA_W-1:0];
                        rx_cnt++;
                    end
                    else
                    begin
                        overrun = 1'b1;
                        frames_dropped++;
                    end
                    frames_done++;
                    eng_busy = 1'b0;
                    bit_cnt = 0;
                end
            end
        end

        res.read_data = rd;
        res.sclk_out  = eng_busy ? (regs.clock_polarity ^ regs.clock_phase ^ second_half)
                                 : regs.clock_polarity;
        res.mosi_out  = eng_busy ? shreg_out[5'(n - 1)] : 1'b0;
        res.select_n  = !eng_busy;
        res.irq_out   = overrun && regs.overrun_irq_mask;
    endtask

    task automatic flag_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_port
        out_item_t     predicted;
        out_item_t     want;
        fixed_result_t f;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FRAME_BITS: regs.frame_bits_minus_one = cfg_data[3:0];
                    CFG_RATE:       regs.clock_rate_divider = cfg_data;
                    CFG_PRESCALE:   regs.prescale_divisor = cfg_data;
                    CFG_POLARITY:   regs.clock_polarity = cfg_data[0];
                    CFG_PHASE:      regs.clock_phase = cfg_data[0];
                    CFG_ENABLE:     regs.port_enable = cfg_data[0];
                    CFG_IRQ_MASK:   regs.overrun_irq_mask = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance_port(in_item, predicted);
                f = fixed_q.pop_front();
                tick_results_q.push_back(f.hand ? f.val : predicted);
            end
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (tick_results_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, out_item);
                end
                else
                begin
                    want = tick_results_q.pop_front();
                    flag_field("read_data", want.read_data, out_item.read_data);
                    flag_field("sclk_out", DATA_W'(want.sclk_out),
                               DATA_W'(out_item.sclk_out));
                    flag_field("mosi_out", DATA_W'(want.mosi_out),
                               DATA_W'(out_item.mosi_out));
                    flag_field("select_n", DATA_W'(want.select_n),
                               DATA_W'(out_item.select_n));
                    flag_field("irq_out", DATA_W'(want.irq_out),
                               DATA_W'(out_item.irq_out));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("spi_master_ssp_controller_test: done, errors");
            $finish;
        end
    end

    // Result side: random stall before each result while rx_idle_on is set, plus one long hold-off on request.
    initial
    begin : take_results
        int unsigned gap;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_outputs)
            begin
                hold_outputs = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            gap = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    task automatic send_item(input in_item_t it, input logic fixed,
                             input logic [DATA_W-1:0] fixed_data);
        int unsigned   gap;
        fixed_result_t f;
        f.hand = fixed;
        f.val = '{read_data: fixed_data, sclk_out: 1'b0, mosi_out: 1'b0,
                  select_n: 1'b1, irq_out: 1'b0};
        fixed_q.push_back(f);
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        items_sent++;
    endtask

    // Stop offering items and wait until every result is back.
    task automatic settle();
        in_valid <= 1'b0;
        while (results_checked != items_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no extra edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    function automatic plan_row_t known_row(input logic [OP_W-1:0] op,
                                            input logic [DATA_W-1:0] data,
                                            input logic miso,
                                            input logic [DATA_W-1:0] rd);
        plan_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = op;
        r.data = data;
        r.miso = miso;
        r.fixed = 1'b1;
        r.fixed_data = rd;
        return r;
    endfunction

    function automatic plan_row_t op_row(input logic [OP_W-1:0] op,
                                         input logic [DATA_W-1:0] data, input logic miso);
        plan_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = op;
        r.data = data;
        r.miso = miso;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic plan_row_t tick_row(input int unsigned reps);
        plan_row_t r;
        r = '0;
        r.kind = ROW_TICKS;
        r.reps = 8'(reps);
        return r;
    endfunction

    function automatic in_item_t random_item(input logic flood);
        in_item_t    it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < (flood ? 55 : 40))
            it.operation = OP_TICK;
        else if (r < (flood ? 80 : 60))
            it.operation = OP_PUSH;
        else if (r < (flood ? 82 : 78))
            it.operation = OP_POP;
        else if (r < 88)
            it.operation = OP_STATUS;
        else if (r < 92)
            it.operation = OP_RAW_IRQ;
        else if (r < 96)
            it.operation = OP_MASKED_IRQ;
        else if (r < 98)
            it.operation = OP_CLEAR_OVR;
        else
            it.operation = OP_SPARE;
        it.write_data = DATA_W'($urandom_range(0, 65535));
        it.miso_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    initial
    begin : drive_port
        plan_row_t   plan [$];
        in_item_t    it;
        int unsigned k;
        int unsigned j;
        int unsigned phase;
        int unsigned count;
        logic        slow;
        logic        flood;
        logic [3:0]  fb;
        logic [7:0]  rate;
        logic [7:0]  pre;
        logic        pol, pha, en, msk;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        plan = '{
            known_row(OP_STATUS, 16'h0000, 1'b0,
                      (16'd1 << STAT_TFE) | (16'd1 << STAT_TNF)),
            known_row(OP_RAW_IRQ, 16'hFFFF, 1'b1, 16'h0000),
            known_row(OP_MASKED_IRQ, 16'h0000, 1'b1, 16'h0000),
            known_row(OP_POP, 16'hFFFF, 1'b0, 16'h0000),
            known_row(OP_SPARE, 16'hFFFF, 1'b1, 16'h0000),
            known_row(OP_CLEAR_OVR, 16'h0000, 1'b0, 16'h0000),
            known_row(OP_PUSH, 16'hFFFF, 1'b1, 16'h0000),
            known_row(OP_PUSH, 16'h0000, 1'b0, 16'h0000),
            known_row(OP_PUSH, 16'h8001, 1'b1, 16'h0000),
            known_row(OP_PUSH, 16'h7FFE, 1'b0, 16'h0000),
            known_row(OP_PUSH, 16'hA5C3, 1'b1, 16'h0000),
            known_row(OP_PUSH, 16'h5A3C, 1'b0, 16'h0000),
            known_row(OP_PUSH, 16'h00FF, 1'b1, 16'h0000),
            known_row(OP_PUSH, 16'hFF00, 1'b0, 16'h0000),
            // The transmit FIFO is full, so this frame is dropped.
            known_row(OP_PUSH, 16'hBEEF, 1'b1, 16'h0000),
            known_row(OP_STATUS, 16'h0000, 1'b0, 16'd1 << STAT_BSY),
            // Frame length below four bits and an odd, tiny prescale.
            reg_row(CFG_FRAME_BITS, 8'd0),
            reg_row(CFG_PRESCALE, 8'd1),
            reg_row(CFG_IRQ_MASK, 8'd1),
            reg_row(CFG_ENABLE, 8'd1),
            tick_row(12),
            // Disable and reshape the port while the second frame is on the wire.
            reg_row(CFG_ENABLE, 8'd0),
            reg_row(CFG_FRAME_BITS, 8'd15),
            reg_row(CFG_POLARITY, 8'd1),
            reg_row(CFG_PHASE, 8'd1),
            tick_row(34),
            op_row(OP_STATUS, 16'h0000, 1'b0),
            op_row(OP_POP, 16'h0000, 1'b1),
            op_row(OP_POP, 16'h0000, 1'b0),
            op_row(OP_MASKED_IRQ, 16'h0000, 1'b1)
        };

        for (k = 0; k < plan.size(); k++)
        begin
            case (plan[k].kind)
                ROW_REG:
                begin
                    if (k == 0 || plan[k-1].kind != ROW_REG)
                        settle();
                    write_reg(plan[k].reg_idx, plan[k].reg_val);
                    if (k + 1 == plan.size() || plan[k+1].kind != ROW_REG)
                        cfg_valid <= 1'b0;
                end
                ROW_TICKS:
                    for (j = 0; j < plan[k].reps; j++)
                    begin
                        it.operation = OP_TICK;
                        it.write_data = DATA_W'($urandom_range(0, 65535));
                        it.miso_in = 1'($urandom_range(0, 1));
                        send_item(it, 1'b0, '0);
                    end
                default:
                begin
                    it.operation = plan[k].op;
                    it.write_data = plan[k].data;
                    it.miso_in = plan[k].miso;
                    send_item(it, plan[k].fixed, plan[k].fixed_data);
                end
            endcase
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            slow = (phase == 4 || phase == 10);
            flood = !slow && (phase % 3 == 1);
            pol = 1'($urandom_range(0, 1));
            pha = 1'($urandom_range(0, 1));
            msk = 1'($urandom_range(0, 1));
            if (phase == 0)
            begin
                fb = 4'd0;
                rate = 8'd0;
                pre = 8'd0;
                en = 1'b1;
            end
            else if (slow)
            begin
                // Widest settings: frames never finish, only the bit timing is seen.
                fb = 4'd15;
                rate = 8'd255;
                pre = (phase == 4) ? 8'd254 : 8'd255;
                en = 1'b1;
            end
            else if (flood)
            begin
                // Fast short frames with rare pops fill the receive FIFO.
                fb = 4'($urandom_range(3, 7));
                rate = 8'd0;
                pre = 8'($urandom_range(0, 4));
                en = 1'b1;
            end
            else
            begin
                fb = 4'($urandom_range(0, 15));
                rate = 8'($urandom_range(0, 1));
                pre = 8'($urandom_range(0, 6));
                en = ($urandom_range(0, 5) != 0);
            end
            tx_idle_on = !(phase % 4 == 3 || phase == 6);
            rx_idle_on = !(phase % 5 == 0 || phase == 6);

            settle();
            write_reg(CFG_FRAME_BITS, {4'd0, fb});
            write_reg(CFG_RATE, rate);
            write_reg(CFG_PRESCALE, pre);
            write_reg(CFG_POLARITY, {7'd0, pol});
            write_reg(CFG_PHASE, {7'd0, pha});
            write_reg(CFG_ENABLE, {7'd0, en});
            write_reg(CFG_IRQ_MASK, {7'd0, msk});
            cfg_valid <= 1'b0;

            if (phase == 2)
                hold_outputs = 1'b1;
            count = slow ? 40 : (flood ? 150 : 100);
            for (j = 0; j < count; j++)
                send_item(random_item(flood), 1'b0, '0);
        end

        settle();
        if (tick_results_q.size() != 0)
        begin
            errors++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, tick_results_q.size());
        end
        $display("Covered %0d ticks over %0d register settings; %0d results compared.",
                 items_sent, NUM_PHASES + 2, results_checked);
        $display("Frames shifted %0d, lost to receive overrun %0d, long output holds %0d.",
                 frames_done, frames_dropped, holds_done);
        if (errors == 0)
            $display("spi_master_ssp_controller_test: done, clean");
        else
            $display("spi_master_ssp_controller_test: done, errors");
        $finish;
    end

endmodule
